### hw/rtl/sde_pkg.sv
// shared constants, codes and types of the square draw engine
package sde_pkg;

    // frame store geometry
    localparam int MAX_SIDE = 256;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

    // field widths
    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 8;
    localparam int HALF_W   = 7;
    localparam int STYLE_W  = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = OP_W;
    localparam int OUT_TDATA_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // style codes
    localparam logic [STYLE_W-1:0] STYLE_BORDER = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_FILL   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0]   SIDE_RESET = CFG_W'(MAX_SIDE);
    localparam logic [LEVEL_W-1:0] BG_RESET   = '0;

    // one input item
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] center_col;
        logic [COORD_W-1:0] center_row;
        logic [HALF_W-1:0]  half_size;
        logic [LEVEL_W-1:0] color;
        logic [STYLE_W-1:0] style;
    } item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic decode;
        logic walk_step;
        logic load_result;
    } sde_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic walk_needed;
        logic walk_last;
        logic out_free;
    } sde_stat_t;

endpackage

### hw/rtl/sde_ram.sv
// generic simple dual port ram with registered read
module sde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sde_datapath.sv
// datapath: config registers, bounds checks, pixel walk counters, frame store, result register
module sde_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sde_pkg::CFG_W-1:0]       cfg_data,
    input  sde_pkg::item_t                  item_in,
    input  sde_pkg::sde_cmd_t               cmd,
    output sde_pkg::sde_stat_t              stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [sde_pkg::LEVEL_W-1:0]     out_pixel,
    output logic [sde_pkg::STATUS_W-1:0]    out_status
);

    import sde_pkg::*;

    logic [CFG_W-1:0]    image_side_reg;
    logic [LEVEL_W-1:0]  background_reg;
    item_t               item_reg;

    logic [SIDE_W-1:0]   side_eff;
    logic [SIDE_W-1:0]   col_ext;
    logic [SIDE_W-1:0]   row_ext;
    logic [SIDE_W-1:0]   half_ext;
    logic                draw_in;
    logic                read_ok;
    logic                style_ok;
    logic                walk_needed;
    logic [STATUS_W-1:0] dec_status;
    logic [COORD_W-1:0]  side_last;

    logic [STATUS_W-1:0] res_status_reg;
    logic                pix_sel_reg;
    logic                clear_mode_reg;
    logic                border_reg;
    logic [COORD_W-1:0]  r_lo_reg;
    logic [COORD_W-1:0]  r_hi_reg;
    logic [COORD_W-1:0]  c_lo_reg;
    logic [COORD_W-1:0]  c_hi_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic                walk_last;

    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  out_pixel_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [LEVEL_W-1:0]  ram_rdata;
    logic [LEVEL_W-1:0]  ram_wdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_side_reg <= SIDE_RESET;
            background_reg <= BG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_SIDE: image_side_reg <= cfg_data;
                CFG_BACKGROUND: background_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item_in;
        end
    end

    // side clamp and bounds checks
    always_comb
    begin
        side_eff  = (image_side_reg > CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                        : SIDE_W'(image_side_reg);
        side_last = COORD_W'(side_eff - SIDE_W'(1));
        col_ext   = SIDE_W'(item_reg.center_col);
        row_ext   = SIDE_W'(item_reg.center_row);
        half_ext  = SIDE_W'(item_reg.half_size);
        // a zero side also fails the far edge test
        draw_in   = (col_ext >= half_ext) && (row_ext >= half_ext)
                  && ((col_ext + half_ext) < side_eff)
                  && ((row_ext + half_ext) < side_eff);
        read_ok   = (col_ext < side_eff) && (row_ext < side_eff);
        style_ok  = (item_reg.style == STYLE_BORDER) || (item_reg.style == STYLE_FILL);
    end

    // decode of operation into status and walk request
    always_comb
    begin
        walk_needed = 1'b0;
        dec_status  = ST_DONE;
        unique case (item_reg.operation)
            OP_CLEAR:
            begin
                walk_needed = (side_eff != '0);
            end
            OP_DRAW:
            begin
                if (!draw_in)
                begin
                    dec_status = ST_REJECT;
                end
                else if (style_ok)
                begin
                    walk_needed = 1'b1;
                end
                else
                begin
                    dec_status = ST_IGNORED;
                end
            end
            OP_READ:
            begin
                dec_status = read_ok ? ST_DONE : ST_REJECT;
            end
            default:
            begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    assign walk_last = (row_reg == r_hi_reg) && (col_reg == c_hi_reg);

    // walk limits and pixel counters
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            res_status_reg <= dec_status;
            pix_sel_reg    <= (item_reg.operation == OP_READ) && read_ok;
            clear_mode_reg <= (item_reg.operation == OP_CLEAR);
            border_reg     <= (item_reg.style == STYLE_BORDER);
            if (item_reg.operation == OP_CLEAR)
            begin
                r_lo_reg <= '0;
                r_hi_reg <= side_last;
                c_lo_reg <= '0;
                c_hi_reg <= side_last;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            else
            begin
                r_lo_reg <= item_reg.center_row - COORD_W'(item_reg.half_size);
                r_hi_reg <= item_reg.center_row + COORD_W'(item_reg.half_size);
                c_lo_reg <= item_reg.center_col - COORD_W'(item_reg.half_size);
                c_hi_reg <= item_reg.center_col + COORD_W'(item_reg.half_size);
                row_reg  <= item_reg.center_row - COORD_W'(item_reg.half_size);
                col_reg  <= item_reg.center_col - COORD_W'(item_reg.half_size);
            end
        end
        else if (cmd.walk_step)
        begin
            if (col_reg == c_hi_reg)
            begin
                col_reg <= c_lo_reg;
                row_reg <= row_reg + COORD_W'(1);
            end
            else if (border_reg && !clear_mode_reg && (col_reg == c_lo_reg)
                     && (row_reg != r_lo_reg) && (row_reg != r_hi_reg))
            begin
                // interior row of an outline: jump to the right edge
                col_reg <= c_hi_reg;
            end
            else
            begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
    end

    assign ram_wdata = clear_mode_reg ? background_reg : item_reg.color;

    // frame store
    sde_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (cmd.walk_step),
        .waddr ({row_reg, col_reg}),
        .wdata (ram_wdata),
        .re    (cmd.decode),
        .raddr ({item_reg.center_row, item_reg.center_col}),
        .rdata (ram_rdata)
    );

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_pixel_reg  <= pix_sel_reg ? ram_rdata : '0;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.walk_needed = walk_needed;
    assign stat.walk_last   = walk_last;
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_pixel        = out_pixel_reg;
    assign out_status       = out_status_reg;

endmodule

### hw/rtl/sde_ctrl.sv
// controller: sequences accept, decode, pixel walk and result hand-off
module sde_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sde_pkg::sde_stat_t  stat,
    output sde_pkg::sde_cmd_t   cmd
);

    import sde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_WALK   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = stat.walk_needed ? S_WALK : S_RESULT;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/square_draw_engine.sv
// top level of the square draw engine: grey-level frame store with clear, draw and read
//
// Usage:
//   s_* stream carries one command per transfer: s_tuser holds the operation
//   (clear, draw square, read pixel) and s_tdata the coordinates, half size,
//   level and style. m_* stream returns exactly one result per command with
//   the pixel level (in-range reads only, zero otherwise) and a status code.
//   cfg_wr_en/cfg_index/cfg_data write image_side (index 0) and
//   background_level (index 1); write them only while no command is in flight.
// Timing: one command is processed at a time. A command goes from transfer
//   through decode and any pixel walk to the result in the output register.
//   The walk writes one pixel per cycle: side*side pixels for a clear,
//   (2h+1)^2 for a filled square, 8h (1 when h is 0) for an outline. Reads
//   and rejected commands skip the walk. The next transfer can be taken in
//   the cycle after the result load.
// Reset: configuration returns to side 256 and background 0; the frame
//   store content is undefined until a clear has been done.
// Stall: the result waits in the output register while m_tready is low;
//   the next command is still taken and worked on, and stops before its
//   result hand-off until the output register is free.
module square_draw_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sde_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sde_pkg::CFG_W-1:0]           cfg_data,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_col[7:0], center_row[15:8], half_size[22:16], color[30:23], style[32:31]
    input  logic [sde_pkg::IN_TDATA_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [sde_pkg::IN_TUSER_W-1:0]      s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel[7:0], status[9:8]
    output logic [sde_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    import sde_pkg::*;

    item_t               item_in;
    sde_cmd_t            cmd;
    sde_stat_t           stat;
    logic [LEVEL_W-1:0]  out_pixel;
    logic [STATUS_W-1:0] out_status;

    // unpack the command transfer
    assign item_in.operation  = s_tuser;
    assign item_in.center_col = s_tdata[7:0];
    assign item_in.center_row = s_tdata[15:8];
    assign item_in.half_size  = s_tdata[22:16];
    assign item_in.color      = s_tdata[30:23];
    assign item_in.style      = s_tdata[32:31];

    sde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sde_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (item_in),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_pixel  (out_pixel),
        .out_status (out_status)
    );

    // pack the result transfer
    assign m_tdata = {{(OUT_TDATA_W - LEVEL_W - STATUS_W){1'b0}}, out_status, out_pixel};

`ifndef ASSERT_OFF
    // a command transfer is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while previous one in flight");

    // no command taken while pixels are being written
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> !s_tready)
        else $error("command taken during pixel walk");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!m_tvalid || m_tready))
        else $error("stalled result overwritten");

    // a nonzero pixel only comes with a done status
    a_pixel_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_pixel != '0)) |-> (out_status == ST_DONE))
        else $error("pixel returned with failing status");
`endif

endmodule
